// ===== rtl/tmtb_pkg.sv =====
// package for the three-mic tdoa bearing block: widths, codes, state enum, atan table
// no dependencies
package tmtb_pkg;
   localparam int SAMPLE_BITS     = 12;
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int CORDIC_STEPS    = 16;
   localparam int ADDR_BITS       = 4;

   localparam logic [1:0] STATUS_NONE    = 2'd0;
   localparam logic [1:0] STATUS_VALID   = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   localparam logic [1:0] REG_TRIGGER = 2'd0;
   localparam logic [1:0] REG_HOLDOFF = 2'd1;
   localparam logic [1:0] REG_WINDOW  = 2'd2;
   localparam logic [1:0] REG_SPACING = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_SQRT, ST_CORDIC, ST_FINISH, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;      // latch update on accepted request
      logic div_step;
      logic sqrt_step;
      logic cordic_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic complete;   // all three latched after update
      logic bad_gap;
   } stat_type;

   function automatic logic [23:0] atan_q16(input logic [3:0] i);
      logic [23:0] v;
      case (i)
         4'd0:  v = 24'd2949120;
         4'd1:  v = 24'd1740967;
         4'd2:  v = 24'd919879;
         4'd3:  v = 24'd466945;
         4'd4:  v = 24'd234379;
         4'd5:  v = 24'd117304;
         4'd6:  v = 24'd58666;
         4'd7:  v = 24'd29335;
         4'd8:  v = 24'd14668;
         4'd9:  v = 24'd7334;
         4'd10: v = 24'd3667;
         4'd11: v = 24'd1833;
         4'd12: v = 24'd917;
         4'd13: v = 24'd458;
         4'd14: v = 24'd229;
         default: v = 24'd115;
      endcase
      return v;
   endfunction
endpackage

// ===== rtl/tmtb_if.sv =====
// valid/ready channel interfaces for request and response
// depends on tmtb_pkg
interface tmtb_req_if;
   logic        valid;
   logic        ready;
   logic [tmtb_pkg::SAMPLE_BITS-1:0] sample_a;
   logic [tmtb_pkg::SAMPLE_BITS-1:0] sample_b;
   logic [tmtb_pkg::SAMPLE_BITS-1:0] sample_c;
   logic [31:0] now_us;
   modport source (output valid, sample_a, sample_b, sample_c, now_us, input ready);
   modport sink (input valid, sample_a, sample_b, sample_c, now_us, output ready);
endinterface

interface tmtb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [8:0]  bearing_deg;
   logic [1:0]  first_mic;
   logic [1:0]  second_mic;
   logic [31:0] gap_us;
   modport source (output valid, status, bearing_deg, first_mic, second_mic, gap_us,
                   input ready);
   modport sink (input valid, status, bearing_deg, first_mic, second_mic, gap_us,
                 output ready);
endinterface

// ===== rtl/tmtb_ctrl.sv =====
// controller state machine: sequences latch update, divide, sqrt, cordic, output
// depends on tmtb_pkg
module tmtb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  tmtb_pkg::stat_type  stat,
   output tmtb_pkg::cmd_type   cmd
);
   import tmtb_pkg::*;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // decide path from latch status
            if (stat.complete && !stat.bad_gap) begin
               state_in = ST_DIV;
               cnt_in   = '0;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_OUT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               state_in = ST_SQRT;
               cnt_in   = '0;
            end
         end
         ST_SQRT: begin
            // load, 17 root digits, then a step that hands the root to the cordic
            cmd.sqrt_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd18) begin
               state_in = ST_CORDIC;
               cnt_in   = '0;
            end
         end
         ST_CORDIC: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(CORDIC_STEPS)) begin
               state_in = ST_OUT;
               cmd.finish = 1'b1;
            end else begin
               cmd.cordic_step = 1'b1;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== rtl/tmtb_dp.sv =====
// datapath: latches, ordering, serial divide, serial sqrt, cordic, sector mapping
// depends on tmtb_pkg
module tmtb_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  tmtb_pkg::cmd_type                cmd,
   output tmtb_pkg::stat_type               stat,
   input  logic [tmtb_pkg::SAMPLE_BITS-1:0] sample_a,
   input  logic [tmtb_pkg::SAMPLE_BITS-1:0] sample_b,
   input  logic [tmtb_pkg::SAMPLE_BITS-1:0] sample_c,
   input  logic [31:0]                      now_us,
   input  logic [11:0]                      trigger_level,
   input  logic [31:0]                      holdoff_us,
   input  logic [31:0]                      window_us,
   input  logic [15:0]                      spacing_us,
   output logic [1:0]                       status,
   output logic [8:0]                       bearing_deg,
   output logic [1:0]                       first_mic,
   output logic [1:0]                       second_mic,
   output logic [31:0]                      gap_us
);
   import tmtb_pkg::*;

   logic [2:0]  latched_ff, latched_in;
   logic [31:0] time_ff [3];
   logic [31:0] time_in [3];
   logic        complete_ff;
   logic [1:0]  first_ff, second_ff, first_in, second_in;
   logic [31:0] gap_ff;
   logic [SAMPLE_BITS-1:0] smp [3];
   logic [2:0]  lat_now;

   // divider: rem/quotient restoring
   logic [16:0] rem_ff, rem_in;
   logic [16:0] quo_ff;
   logic [17:0] rem_sh;
   // sqrt of 2^32 - r*r, radicand fed two bits a step
   logic [33:0] rad_ff;
   logic [17:0] root_ff;
   logic [19:0] srem_ff;
   logic [19:0] strial, srem_sh;
   logic        sqrt_load_ff;
   // cordic
   logic signed [19:0] cx_ff, cy_ff;
   logic signed [24:0] cz_ff;
   logic [3:0]  ci_ff;
   logic signed [24:0] zc;
   logic signed [ANGLE_FRAC_BITS+9:0] zs, aa, bb;
   logic [1:0]  status_ff;
   logic [8:0]  bear_ff;

   assign smp[0] = sample_a;
   assign smp[1] = sample_b;
   assign smp[2] = sample_c;

   always_comb begin
      lat_now = latched_ff;
      for (int i = 0; i < 3; i++) begin
         time_in[i] = time_ff[i];
         if (!latched_ff[i] && (SAMPLE_BITS'(trigger_level) < smp[i])
             && (now_us - time_ff[i] > holdoff_us)) begin
            time_in[i] = now_us;
            lat_now[i] = 1'b1;
         end
      end
      latched_in = lat_now;
      for (int i = 0; i < 3; i++)
         if (lat_now[i] && (now_us - time_in[i] > window_us)) latched_in = 3'b000;
      if (latched_in == 3'b111) latched_in = 3'b000;
      // ordering
      if (time_in[0] < time_in[1] && time_in[0] < time_in[2]) first_in = 2'd0;
      else if (time_in[1] < time_in[2]) first_in = 2'd1;
      else first_in = 2'd2;
      case (first_in)
         2'd0: second_in = (time_in[1] < time_in[2]) ? 2'd1 : 2'd2;
         2'd1: second_in = (time_in[0] < time_in[2]) ? 2'd0 : 2'd2;
         default: second_in = (time_in[0] < time_in[1]) ? 2'd0 : 2'd1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff  <= '0;
         complete_ff <= 1'b0;
         for (int i = 0; i < 3; i++) time_ff[i] <= '0;
      end else if (cmd.start) begin
         latched_ff  <= latched_in;
         complete_ff <= (lat_now == 3'b111) && (latched_in == 3'b000) &&
                        !((now_us - time_in[0] > window_us) ||
                          (now_us - time_in[1] > window_us) ||
                          (now_us - time_in[2] > window_us));
         for (int i = 0; i < 3; i++) time_ff[i] <= time_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         first_ff  <= first_in;
         second_ff <= second_in;
         gap_ff    <= time_in[second_in] - time_in[first_in];
      end
   end

   assign stat.complete = complete_ff;
   assign stat.bad_gap  = gap_ff > {16'd0, spacing_us};

   // restoring divide gap*65536/spacing, gap <= spacing so 17 quotient bits
   assign rem_sh = {rem_ff, 1'b0};
   always_comb begin
      rem_in = rem_sh[16:0];
      if (rem_sh >= {2'b00, spacing_us}) rem_in = 17'(rem_sh - {2'b00, spacing_us});
   end

   assign srem_sh = {srem_ff[17:0], rad_ff[33:32]};
   assign strial  = {root_ff[17:0], 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         if (quo_ff == 17'd0 && rem_ff == 17'd0) begin
            // first step loads dividend high part (gap fits in 16+1 bits)
            if (spacing_us == 16'd0) begin
               quo_ff <= '0;
               rem_ff <= 17'h1ffff;
            end else begin
               quo_ff <= {16'd0, (gap_ff[16:0] >= {1'b0, spacing_us})};
               rem_ff <= (gap_ff[16:0] >= {1'b0, spacing_us}) ?
                         17'(gap_ff[16:0] - {1'b0, spacing_us}) : gap_ff[16:0];
            end
         end else if (rem_ff != 17'h1ffff) begin
            quo_ff <= {quo_ff[15:0], (rem_sh >= {2'b00, spacing_us})};
            rem_ff <= rem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_step) begin
         srem_ff      <= '0;
         root_ff      <= '0;
         rad_ff       <= 34'h1_0000_0000;
         sqrt_load_ff <= 1'b1;
      end else if (cmd.sqrt_step) begin
         sqrt_load_ff <= 1'b0;
         if (sqrt_load_ff)
            rad_ff <= 34'h1_0000_0000 - 34'((rem_ff == 17'h1ffff ? 34'd0 : 34'(quo_ff))
                      * (rem_ff == 17'h1ffff ? 34'd0 : 34'(quo_ff)));
         else begin
            if (srem_sh >= strial) begin
               srem_ff <= 20'(srem_sh - strial);
               root_ff <= {root_ff[16:0], 1'b1};
            end else begin
               srem_ff <= srem_sh;
               root_ff <= {root_ff[16:0], 1'b0};
            end
            rad_ff <= {rad_ff[31:0], 2'b00};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_step) begin
         cx_ff <= (rem_ff == 17'h1ffff) ? 20'sd0 : signed'(20'(quo_ff));
         cy_ff <= signed'(20'(root_ff));
         cz_ff <= '0;
         ci_ff <= '0;
      end else if (cmd.cordic_step) begin
         ci_ff <= ci_ff + 4'd1;
         if (cy_ff > 0) begin
            cx_ff <= cx_ff + (cy_ff >>> ci_ff);
            cy_ff <= cy_ff - (cx_ff >>> ci_ff);
            cz_ff <= cz_ff + signed'({1'b0, atan_q16(ci_ff)});
         end else begin
            cx_ff <= cx_ff + ((-cy_ff) >>> ci_ff);
            cy_ff <= cy_ff + (cx_ff >>> ci_ff);
            cz_ff <= cz_ff - signed'({1'b0, atan_q16(ci_ff)});
         end
      end
   end

   always_comb begin
      zc = cz_ff;
      if (zc < 0) zc = '0;
      if (zc > 25'sd5898240) zc = 25'sd5898240;
      zs = (ANGLE_FRAC_BITS+10)'(zc >>> (16 - ANGLE_FRAC_BITS));
      aa = zs - (ANGLE_FRAC_BITS+10)'(30 <<< ANGLE_FRAC_BITS);
      if (aa < 0) aa = -aa;
      case ({first_ff, second_ff})
         4'b0001: bb = aa;
         4'b0010: bb = (ANGLE_FRAC_BITS+10)'(360 <<< ANGLE_FRAC_BITS) - aa;
         4'b0100: bb = (ANGLE_FRAC_BITS+10)'(120 <<< ANGLE_FRAC_BITS) - aa;
         4'b0110: bb = (ANGLE_FRAC_BITS+10)'(120 <<< ANGLE_FRAC_BITS) + aa;
         4'b1000: bb = (ANGLE_FRAC_BITS+10)'(240 <<< ANGLE_FRAC_BITS) + aa;
         default: bb = (ANGLE_FRAC_BITS+10)'(240 <<< ANGLE_FRAC_BITS) - aa;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (!complete_ff) begin
            status_ff <= STATUS_NONE;
            bear_ff   <= '0;
         end else if (stat.bad_gap) begin
            status_ff <= STATUS_INVALID;
            bear_ff   <= '0;
         end else begin
            status_ff <= STATUS_VALID;
            bear_ff   <= bb[ANGLE_FRAC_BITS+8:ANGLE_FRAC_BITS];
         end
      end
   end

   assign status      = status_ff;
   assign bearing_deg = bear_ff;
   assign first_mic   = (status_ff == STATUS_NONE) ? 2'd0 : first_ff;
   assign second_mic  = (status_ff == STATUS_NONE) ? 2'd0 : second_ff;
   assign gap_us      = (status_ff == STATUS_NONE) ? 32'd0 : gap_ff;
endmodule

// ===== rtl/tmtb_csr.sv =====
// apb register file for trigger level, holdoff, window, spacing
// depends on tmtb_pkg
module tmtb_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tmtb_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready,
   output logic [11:0]                  trigger_level,
   output logic [31:0]                  holdoff_us,
   output logic [31:0]                  window_us,
   output logic [15:0]                  spacing_us
);
   import tmtb_pkg::*;

   logic [11:0] trig_ff;
   logic [31:0] hold_ff, win_ff;
   logic [15:0] spc_ff;
   logic        wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff <= 12'd512;
         hold_ff <= 32'd1000;
         win_ff  <= 32'd100000;
         spc_ff  <= 16'd300;
      end else if (wr) begin
         unique case (paddr[3:2])
            REG_TRIGGER: trig_ff <= pwdata[11:0];
            REG_HOLDOFF: hold_ff <= pwdata;
            REG_WINDOW:  win_ff  <= pwdata;
            REG_SPACING: spc_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_TRIGGER: prdata = {20'd0, trig_ff};
         REG_HOLDOFF: prdata = hold_ff;
         REG_WINDOW:  prdata = win_ff;
         REG_SPACING: prdata = {16'd0, spc_ff};
         default:     prdata = '0;
      endcase
   end

   assign trigger_level = trig_ff;
   assign holdoff_us    = hold_ff;
   assign window_us     = win_ff;
   assign spacing_us    = spc_ff;
endmodule

// ===== rtl/three_mic_tdoa_bearing_top.sv =====
// three-mic tdoa bearing finder: one response per request
// sequence: when no bearing is formed, a decide state then the response; with a bearing,
// decide, divide, sqrt, cordic, then output, plus any wait for the response to be taken
// throughput: one request at a time, next accepted the cycle after the response is taken
// reset: synchronous; clears latches, latch times and restores register defaults
module three_mic_tdoa_bearing_top (
   input  logic                           clock,
   input  logic                           reset,
   tmtb_req_if.sink                       req,
   tmtb_rsp_if.source                     rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tmtb_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import tmtb_pkg::*;

   cmd_type     cmd;
   stat_type    stat;
   logic [11:0] trig;
   logic [31:0] hold, win;
   logic [15:0] spc;

   tmtb_csr u_csr (
      .clock, .reset,
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata), .pready(csr_pready),
      .trigger_level(trig), .holdoff_us(hold), .window_us(win), .spacing_us(spc)
   );

   tmtb_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .stat, .cmd
   );

   tmtb_dp u_dp (
      .clock, .reset, .cmd, .stat,
      .sample_a(req.sample_a), .sample_b(req.sample_b), .sample_c(req.sample_c),
      .now_us(req.now_us),
      .trigger_level(trig), .holdoff_us(hold), .window_us(win), .spacing_us(spc),
      .status(rsp.status), .bearing_deg(rsp.bearing_deg),
      .first_mic(rsp.first_mic), .second_mic(rsp.second_mic), .gap_us(rsp.gap_us)
   );
endmodule

// ===== rtl/tmtb_checker.sv =====
// port-level checker for the bearing top level, bound to it
// depends on tmtb_pkg
module tmtb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [8:0]  rsp_bearing_deg
);
   import tmtb_pkg::*;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken during response");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("bad status");
   a_bear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_VALID |-> rsp_bearing_deg == 9'd0)
      else $error("bearing without valid status");
endmodule

bind three_mic_tdoa_bearing_top tmtb_checker u_chk (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_bearing_deg(rsp.bearing_deg)
);

// ===== test/tb.sv =====
// testbench for three_mic_tdoa_bearing_top: directed table, then random tick streams
// depends on tmtb_pkg, tmtb_req_if, tmtb_rsp_if and the rtl top
`timescale 1ns / 100ps

module tb;
   import tmtb_pkg::*;

   localparam int FRAC = ANGLE_FRAC_BITS;
   localparam int SETTLE = 80;
   localparam int STALL_LIMIT = 5000;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_a;
      logic [SAMPLE_BITS-1:0] sample_b;
      logic [SAMPLE_BITS-1:0] sample_c;
      logic [31:0]            now_us;
   } tick_t;

   typedef struct packed {
      logic [1:0]  status;
      logic [8:0]  bearing_deg;
      logic [1:0]  first_mic;
      logic [1:0]  second_mic;
      logic [31:0] gap_us;
   } bearing_t;

   typedef struct {
      tick_t    tick;
      bit       typed;
      bearing_t want;
   } dir_row_t;

   localparam longint ATAN_DEG_Q16 [16] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115
   };

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [ADDR_BITS-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   tmtb_req_if req ();
   tmtb_rsp_if rsp ();

   three_mic_tdoa_bearing_top dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // predictor copy of block state and registers
   logic [11:0] trig_lvl;
   logic [31:0] holdoff, window;
   logic [15:0] spacing;
   bit          mic_latched [3];
   logic [31:0] mic_time [3];

   bearing_t pending_bearings [$];
   int errors, mismatches, n_reqs, n_rsps, n_csr, n_valid, n_invalid;
   bit calm, hold_request;
   logic [31:0] cur_us;

   function automatic logic [31:0] root64(logic [63:0] v);
      logic [63:0] res, bv;
      res = 0;
      bv = 64'h1_0000_0000;
      while (bv > v) bv = bv >> 2;
      while (bv != 0) begin
         if (v >= res + bv) begin
            v = v - (res + bv);
            res = (res >> 1) + bv;
         end else begin
            res = res >> 1;
         end
         bv = bv >> 2;
      end
      return res[31:0];
   endfunction

   function automatic longint acos_deg_q16(logic [31:0] r);
      longint x, y, z, nx, ny;
      x = r;
      y = root64(64'h1_0000_0000 - 64'(r) * 64'(r));
      z = 0;
      for (int i = 0; i < 16; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += ATAN_DEG_Q16[i];
         end else begin
            nx = x + ((-y) >>> i);
            ny = y + (x >>> i);
            z -= ATAN_DEG_Q16[i];
         end
         x = nx;
         y = ny;
      end
      if (z < 0) z = 0;
      if (z > 90 * 65536) z = 90 * 65536;
      return z;
   endfunction

   function automatic bearing_t locate(tick_t t);
      bearing_t o;
      logic [SAMPLE_BITS-1:0] s [3];
      logic [31:0] tm [3];
      logic [31:0] gap, r;
      bit stale;
      int f, sc;
      longint a, b;
      o = '0;
      s[0] = t.sample_a;
      s[1] = t.sample_b;
      s[2] = t.sample_c;
      stale = 0;
      for (int i = 0; i < 3; i++)
         if (!mic_latched[i] && s[i] > trig_lvl && (t.now_us - mic_time[i]) > holdoff) begin
            mic_time[i] = t.now_us;
            mic_latched[i] = 1;
         end
      for (int i = 0; i < 3; i++)
         if (mic_latched[i] && (t.now_us - mic_time[i]) > window) stale = 1;
      if (stale) for (int i = 0; i < 3; i++) mic_latched[i] = 0;
      if (!(mic_latched[0] && mic_latched[1] && mic_latched[2])) begin
         o.status = STATUS_NONE;
         return o;
      end
      for (int i = 0; i < 3; i++) begin
         tm[i] = mic_time[i];
         mic_latched[i] = 0;
      end
      if (tm[0] < tm[1] && tm[0] < tm[2]) f = 0;
      else if (tm[1] < tm[2]) f = 1;
      else f = 2;
      if (f == 0) sc = (tm[1] < tm[2]) ? 1 : 2;
      else if (f == 1) sc = (tm[0] < tm[2]) ? 0 : 2;
      else sc = (tm[0] < tm[1]) ? 0 : 1;
      gap = tm[sc] - tm[f];
      o.first_mic = f[1:0];
      o.second_mic = sc[1:0];
      o.gap_us = gap;
      if (gap > spacing) begin
         o.status = STATUS_INVALID;
         return o;
      end
      r = (spacing == 0) ? 32'd0 : 32'((64'(gap) << 16) / spacing);
      a = (acos_deg_q16(r) >>> (16 - FRAC)) - (longint'(30) << FRAC);
      if (a < 0) a = -a;
      if (f == 0 && sc == 1) b = a;
      else if (f == 0 && sc == 2) b = (longint'(360) << FRAC) - a;
      else if (f == 1 && sc == 0) b = (longint'(120) << FRAC) - a;
      else if (f == 1 && sc == 2) b = (longint'(120) << FRAC) + a;
      else if (f == 2 && sc == 0) b = (longint'(240) << FRAC) + a;
      else b = (longint'(240) << FRAC) - a;
      o.status = STATUS_VALID;
      o.bearing_deg = 9'(b >>> FRAC);
      return o;
   endfunction

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // watchdog on lack of progress
   initial begin
      int idle, last;
      idle = 0;
      last = 0;
      forever begin
         @(posedge clock);
         if (n_reqs + n_rsps + n_csr != last) begin
            last = n_reqs + n_rsps + n_csr;
            idle = 0;
         end else if (++idle >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", idle);
            $display("three_mic_tdoa_bearing_top verification failed");
            $finish;
         end
      end
   end

   // response side: check and random back-pressure
   initial begin
      int hold;
      bearing_t want;
      rsp.ready <= 0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            n_rsps++;
            if (pending_bearings.size() == 0) begin
               errors++;
               if (++mismatches <= 10) $display("response with nothing pending: %p", rsp.status);
            end else begin
               want = pending_bearings.pop_front();
               if (rsp.status !== want.status || rsp.bearing_deg !== want.bearing_deg ||
                   rsp.first_mic !== want.first_mic || rsp.second_mic !== want.second_mic ||
                   rsp.gap_us !== want.gap_us) begin
                  errors++;
                  if (++mismatches <= 10)
                     $display("mismatch: want st %0d deg %0d f %0d s %0d gap %0d, got %0d %0d %0d %0d %0d",
                              want.status, want.bearing_deg, want.first_mic, want.second_mic,
                              want.gap_us, rsp.status, rsp.bearing_deg, rsp.first_mic,
                              rsp.second_mic, rsp.gap_us);
               end
            end
         end
         if (hold_request && hold == 0) begin
            hold = 400;
            hold_request = 0;
         end
         if (hold > 0) begin
            hold--;
            rsp.ready <= 0;
         end else begin
            rsp.ready <= calm || ($urandom_range(0, 99) >= 8);
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= ADDR_BITS'(idx) << 2;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      n_csr++;
      case (idx)
         REG_TRIGGER: trig_lvl = val[11:0];
         REG_HOLDOFF: holdoff = val;
         REG_WINDOW:  window = val;
         default:     spacing = val[15:0];
      endcase
   endtask

   task automatic drain();
      while (pending_bearings.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(logic [11:0] tl, logic [31:0] ho, logic [31:0] wi,
                            logic [15:0] sp);
      drain();
      csr_write(REG_TRIGGER, 32'(tl));
      csr_write(REG_HOLDOFF, ho);
      csr_write(REG_WINDOW, wi);
      csr_write(REG_SPACING, 32'(sp));
   endtask

   // drives one request, holds it until taken, then queues its expected bearing
   task automatic send(tick_t t, bit typed, bearing_t typed_want);
      bearing_t want;
      @(posedge clock);
      while (!calm && $urandom_range(0, 99) < 8) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1;
      req.sample_a <= t.sample_a;
      req.sample_b <= t.sample_b;
      req.sample_c <= t.sample_c;
      req.now_us <= t.now_us;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      n_reqs++;
      want = locate(t);
      if (typed) want = typed_want;
      if (want.status == STATUS_VALID) n_valid++;
      if (want.status == STATUS_INVALID) n_invalid++;
      pending_bearings.push_back(want);
      req.valid <= 0;
   endtask

   function automatic logic [11:0] pick_sample(bit loud);
      if (trig_lvl == 12'hFFF) return 12'($urandom);
      if (loud) return 12'($urandom_range(int'(trig_lvl) + 1, 4095));
      return 12'($urandom_range(0, int'(trig_lvl)));
   endfunction

   task automatic random_ticks(int n, int max_step);
      tick_t t;
      for (int k = 0; k < n; k++) begin
         calm = (k >= n / 4 && k < n / 4 + 120);
         if (k == n / 2) hold_request = 1;
         if (k == 3 * n / 4) drain();
         if ($urandom_range(0, 99) < 3) cur_us = $urandom;
         else if ($urandom_range(0, 99) < 5) cur_us += $urandom_range(0, 200000);
         else cur_us += $urandom_range(0, max_step);
         t.now_us = cur_us;
         t.sample_a = pick_sample($urandom_range(0, 7) == 0);
         t.sample_b = pick_sample($urandom_range(0, 7) == 0);
         t.sample_c = pick_sample($urandom_range(0, 7) == 0);
         send(t, 0, '0);
      end
      calm = 0;
   endtask

   dir_row_t dir_rows [17];

   initial begin
      bearing_t nothing;
      nothing = '0;
      dir_rows = '{
         '{'{12'd0, 12'd0, 12'd0, 32'd0}, 1, nothing},
         '{'{12'hFFF, 12'd0, 12'd0, 32'd2000}, 1, nothing},
         '{'{12'd0, 12'hFFF, 12'd0, 32'd2500}, 1, nothing},
         '{'{12'd0, 12'd0, 12'hFFF, 32'd2600}, 1,
           '{STATUS_INVALID, 9'd0, 2'd0, 2'd1, 32'd500}},
         '{'{12'hFFF, 12'hFFF, 12'hFFF, 32'd5000}, 0, nothing},
         '{'{12'd512, 12'd512, 12'd512, 32'd7000}, 1, nothing},
         '{'{12'd513, 12'd0, 12'd0, 32'd7000}, 1, nothing},
         '{'{12'd0, 12'd513, 12'd0, 32'd7100}, 1, nothing},
         '{'{12'd0, 12'd0, 12'd513, 32'd7400}, 0, nothing},
         '{'{12'hFFF, 12'd0, 12'd0, 32'd10000}, 1, nothing},
         '{'{12'd0, 12'hFFF, 12'd0, 32'd200001}, 1, nothing},
         '{'{12'hFFF, 12'd0, 12'd0, 32'd300000}, 1, nothing},
         '{'{12'd0, 12'hFFF, 12'd0, 32'd300300}, 1, nothing},
         '{'{12'd0, 12'd0, 12'hFFF, 32'd300400}, 0, nothing},
         '{'{12'd0, 12'd0, 12'hFFF, 32'hFFFF_FF00}, 1, nothing},
         '{'{12'hFFF, 12'd0, 12'd0, 32'hFFFF_FFA0}, 1, nothing},
         '{'{12'd0, 12'hFFF, 12'd0, 32'h0000_0010}, 1,
           '{STATUS_INVALID, 9'd0, 2'd1, 2'd2, 32'hFFFF_FEF0}}
      };

      reset <= 1;
      req.valid <= 0;
      req.sample_a <= 0;
      req.sample_b <= 0;
      req.sample_c <= 0;
      req.now_us <= 0;
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      csr_paddr <= 0;
      csr_pwdata <= 0;
      calm = 0;
      hold_request = 0;
      trig_lvl = 512;
      holdoff = 1000;
      window = 100000;
      spacing = 300;
      for (int i = 0; i < 3; i++) begin
         mic_latched[i] = 0;
         mic_time[i] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 0;

      foreach (dir_rows[i]) send(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
      cur_us = 400000;

      random_ticks(500, 60);
      configure(12'd0, 32'd0, 32'hFFFF_FFFF, 16'd1);
      random_ticks(300, 2);
      configure(12'd2048, 32'd200, 32'd1500, 16'd65535);
      random_ticks(400, 300);
      configure(12'hFFF, 32'hFFFF_FFFF, 32'd0, 16'd300);
      random_ticks(150, 60);
      configure(12'($urandom_range(100, 3000)), 32'($urandom_range(0, 3000)),
                32'($urandom_range(500, 50000)), 16'($urandom_range(50, 1000)));
      random_ticks(650, 80);

      drain();
      $display("%0d requests, %0d bearings valid, %0d gaps out of range, %0d register writes",
               n_reqs, n_valid, n_invalid, n_csr);
      $display("covered ties, wrapped timestamps, stale window clears and five register sets");
      if (errors == 0 && pending_bearings.size() == 0) begin
         $display("three_mic_tdoa_bearing_top verification clean");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, pending_bearings.size());
         $display("three_mic_tdoa_bearing_top verification failed");
      end
      $finish;
   end
endmodule
